>>> rtl/core/rdps_pkg.sv
// shared types, constants and helper functions for the pwm duty sequencer
package rdps_pkg;

    // field widths
    localparam int unsigned OP_W    = 1;
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned UPD_W   = 10;
    localparam int unsigned PER_W   = 24;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    // defaults and limits
    localparam int unsigned TABLE_DEPTH_DEF = 4096;
    localparam logic [MODE_W-1:0] MODE_LAST  = 3'd5;
    localparam logic [PER_W-1:0]  PERIOD_RST = 24'd200000;

    // item opcodes
    localparam logic [OP_W-1:0] OP_TICK  = 1'b0;
    localparam logic [OP_W-1:0] OP_WRITE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_MODE_PERIOD = 1'b0;

    // events raised by one tick
    typedef struct packed {
        logic upd;
        logic sw;
    } t_tmr_evt;

    // update interval in ticks for each mode
    function automatic logic [UPD_W-1:0] interval_of(input logic [MODE_W-1:0] mode);
        logic [UPD_W-1:0] iv;
        case (mode)
            3'd0: iv = 10'd1000;
            3'd1: iv = 10'd500;
            3'd2: iv = 10'd333;
            3'd3: iv = 10'd250;
            3'd4: iv = 10'd200;
            3'd5: iv = 10'd166;
            default: iv = 10'd1000;
        endcase
        return iv;
    endfunction

    // v*1023/255 equals 4v + floor(v/85) for an 8-bit v
    function automatic logic [DUTY_W-1:0] byte_to_duty(input logic [BYTE_W-1:0] v);
        logic [1:0] corr;
        if (v == 8'd255) begin
            corr = 2'd3;
        end else if (v >= 8'd170) begin
            corr = 2'd2;
        end else if (v >= 8'd85) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
        return {v, 2'b00} + {8'd0, corr};
    endfunction

endpackage

>>> rtl/core/rdps_ram.sv
// generic single-write, single-read ram with registered read data
module rdps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rdps_cfg.sv
// apb register block holding the mode switch period
module rdps_cfg
    import rdps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [PER_W-1:0]  o_period
);

    logic [PER_W-1:0] r_period;
    logic             w_wr;

    // write strobe on the access phase
    assign w_wr = psel && penable && pwrite && (paddr[2] == REG_MODE_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
        end else if (w_wr) begin
            r_period <= pwdata[PER_W-1:0];
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MODE_PERIOD) begin
            prdata = {{(APB_DW-PER_W){1'b0}}, r_period};
        end
    end

    assign pready   = 1'b1;
    assign o_period = r_period;

endmodule

>>> rtl/core/rdps_timer.sv
// update and mode counters, mode register and table read position
module rdps_timer
    import rdps_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tick,
    input  logic [PER_W-1:0]               i_period,
    output t_tmr_evt                       o_evt,
    output logic [MODE_W-1:0]              o_mode,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_pos_next
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] POS_LAST = AW'(TABLE_DEPTH - 1);

    logic [UPD_W-1:0]  r_upd_cnt, n_upd_cnt;
    logic [PER_W-1:0]  r_mode_cnt, n_mode_cnt;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [AW-1:0]     r_pos, n_pos;
    logic [UPD_W-1:0]  w_ue;
    logic [PER_W-1:0]  w_me;
    logic              w_upd_hit;
    logic              w_sw_hit;

    // counter compares use the mode from before any switch
    assign w_ue      = r_upd_cnt + 1'b1;
    assign w_me      = r_mode_cnt + 1'b1;
    assign w_upd_hit = (w_ue >= interval_of(r_mode));
    assign w_sw_hit  = (w_me >= i_period);

    always_comb begin
        n_upd_cnt  = r_upd_cnt;
        n_mode_cnt = r_mode_cnt;
        n_mode     = r_mode;
        n_pos      = r_pos;
        if (i_tick) begin
            // duty update path
            if (w_upd_hit) begin
                n_upd_cnt = '0;
                n_pos     = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
            end else begin
                n_upd_cnt = w_ue;
            end
            // mode switch path
            if (w_sw_hit) begin
                n_mode_cnt = '0;
                n_mode     = (r_mode >= MODE_LAST) ? '0 : r_mode + 1'b1;
            end else begin
                n_mode_cnt = w_me;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd_cnt  <= '0;
            r_mode_cnt <= '0;
            r_mode     <= '0;
            r_pos      <= '0;
        end else begin
            r_upd_cnt  <= n_upd_cnt;
            r_mode_cnt <= n_mode_cnt;
            r_mode     <= n_mode;
            r_pos      <= n_pos;
        end
    end

    assign o_evt.upd  = i_tick && w_upd_hit;
    assign o_evt.sw   = i_tick && w_sw_hit;
    assign o_mode     = r_mode;
    assign o_pos_next = n_pos;

endmodule

>>> rtl/core/random_duty_pwm_sequencer_core.sv
// top level of the pwm duty sequencer: input register, table, counters, result register
//
// Usage: each input transfer is either a 1 us tick (i_op = tick) or a write of one
// duty table byte (i_op = write, i_entry_index, i_entry_value). Load the table entries
// before ticks reach them. Every accepted item gives exactly one result transfer:
// o_duty (10-bit duty, held between updates), o_duty_updated, o_mode, o_mode_switched.
// Both channels use valid/stall; a transfer happens when valid is high and stall low.
// The mode switch period is written over the apb port (byte address 0).
// An item is registered on acceptance; its result is registered when the result
// register is empty or the receiver does not stall it.
// Throughput: one item per cycle unless the receiver stalls; per-item work is only a
// counter compare, a table read issued in the cycle before, and the duty scaling.
// A write to the entry being prefetched is forwarded, so a tick may follow a write
// to the same entry directly.
// Reset clears counters, mode, duty, position and both pipeline stages; the table
// keeps whatever it held. When the receiver stalls, the result register holds and
// one more item waits in the input register, after which input stall rises.
module random_duty_pwm_sequencer_core
    import rdps_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_op,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [BYTE_W-1:0] i_entry_value,
    // result output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DUTY_W-1:0] o_duty,
    output logic              o_duty_updated,
    output logic [MODE_W-1:0] o_mode,
    output logic              o_mode_switched,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    // input register
    logic              r_in_valid, n_in_valid;
    logic [OP_W-1:0]   r_in_op;
    logic [IDX_W-1:0]  r_in_idx;
    logic [BYTE_W-1:0] r_in_val;

    // result register
    logic              r_out_valid, n_out_valid;
    logic              r_out_upd;
    logic              r_out_sw;
    logic [DUTY_W-1:0] r_duty, n_duty;

    // forwarding of a write that lands on the prefetched entry
    logic              r_byp_hit;
    logic [BYTE_W-1:0] r_byp_data;

    logic              w_accept;
    logic              w_adv;
    logic              w_proc;
    logic              w_tick;
    logic              w_we;
    logic [31:0]       w_idx_ext;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [BYTE_W-1:0] w_rdata;
    logic [BYTE_W-1:0] w_entry;
    logic [PER_W-1:0]  w_period;
    logic [MODE_W-1:0] w_mode;
    t_tmr_evt          w_evt;

    // handshake control
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_tick     = w_proc && (r_in_op == OP_TICK);

    // table write decode, out-of-range writes are dropped
    assign w_idx_ext = 32'(r_in_idx);
    assign w_waddr   = w_idx_ext[AW-1:0];
    assign w_we      = w_proc && (r_in_op == OP_WRITE) && (w_idx_ext < 32'(TABLE_DEPTH));

    rdps_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_period (w_period)
    );

    rdps_timer #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_timer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_tick),
        .i_period   (w_period),
        .o_evt      (w_evt),
        .o_mode     (w_mode),
        .o_pos_next (w_raddr)
    );

    // table read is registered and addressed with the position the next item will use
    rdps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_in_val),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_entry = r_byp_hit ? r_byp_data : w_rdata;

    // next state of both stages
    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = r_in_valid;
        end
        n_duty = r_duty;
        if (w_evt.upd) begin
            n_duty = byte_to_duty(w_entry);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_duty      <= '0;
            r_byp_hit   <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_duty      <= n_duty;
            r_byp_hit   <= w_we && (w_waddr == w_raddr);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op  <= i_op;
            r_in_idx <= i_entry_index;
            r_in_val <= i_entry_value;
        end
        if (w_proc) begin
            r_out_upd <= w_evt.upd;
            r_out_sw  <= w_evt.sw;
        end
        r_byp_data <= r_in_val;
    end

    assign o_out_valid     = r_out_valid;
    assign o_duty          = r_duty;
    assign o_duty_updated  = r_out_upd;
    assign o_mode          = w_mode;
    assign o_mode_switched = r_out_sw;

endmodule

>>> rtl/core/rdps_checker.sv
// port-level checker for the pwm duty sequencer, bound to the top level
module rdps_checker
    import rdps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [DUTY_W-1:0] o_duty,
    input  logic [MODE_W-1:0] o_mode,
    input  logic              o_duty_updated,
    input  logic              pready
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_duty) && $stable(o_mode))
        else $error("result changed while stalled");

    // mode never leaves the six legal settings
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_mode <= MODE_LAST))
        else $error("mode out of range");

    // duty only moves on a transfer flagged as an update
    a_duty_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid && !o_duty_updated
            |-> $stable(o_duty))
        else $error("duty changed without update flag");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // the configuration port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind random_duty_pwm_sequencer_core rdps_checker u_rdps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_duty         (o_duty),
    .o_mode         (o_mode),
    .o_duty_updated (o_duty_updated),
    .pready         (pready)
);

>>> tb/tb_random_duty_pwm_sequencer_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the random duty pwm sequencer core
module tb_random_duty_pwm_sequencer_core;
    import rdps_pkg::*;

    localparam int unsigned DEPTH         = TABLE_DEPTH_DEF;
    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 225;
    localparam logic [APB_AW-1:0] ADDR_MODE_PERIOD = {REG_MODE_PERIOD, 2'b00};

    // one result transfer as seen on the output channel
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              duty_updated;
        logic [MODE_W-1:0] mode;
        logic              mode_switched;
    } t_duty_result;

    // duty sequencer predictor and queue of expected results
    class duty_scoreboard;
        logic [BYTE_W-1:0] entries [DEPTH];
        bit                loaded  [DEPTH];
        int unsigned       pos;
        logic [UPD_W-1:0]  upd_elapsed;
        logic [PER_W-1:0]  mode_elapsed;
        logic [MODE_W-1:0] cur_mode;
        logic [DUTY_W-1:0] duty_q;
        logic [PER_W-1:0]  period;
        t_duty_result      pending [$];
        int unsigned       errors;

        function new();
            pos          = 0;
            upd_elapsed  = '0;
            mode_elapsed = '0;
            cur_mode     = '0;
            duty_q       = '0;
            period       = PERIOD_RST;
            errors       = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        // ticks between duty updates for a mode
        function int unsigned update_interval(logic [MODE_W-1:0] m);
            case (m)
                3'd0: return 1000;
                3'd1: return 500;
                3'd2: return 333;
                3'd3: return 250;
                3'd4: return 200;
                3'd5: return 166;
                default: return 1000;
            endcase
        endfunction

        function bit next_tick_updates();
            logic [UPD_W-1:0] nxt;
            nxt = upd_elapsed + 1'b1;
            return nxt >= update_interval(cur_mode);
        endfunction

        function void set_period(logic [APB_DW-1:0] data);
            period = data[PER_W-1:0];
        endfunction

        // advance the predicted state by one accepted input transfer
        function void note_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                logic [BYTE_W-1:0] val);
            t_duty_result     want;
            logic [UPD_W-1:0] nxt_upd;
            logic [PER_W-1:0] nxt_mode;
            int unsigned      scaled;
            want.duty_updated  = 1'b0;
            want.mode_switched = 1'b0;
            if (op == OP_WRITE) begin
                if (int'(idx) < DEPTH) begin
                    entries[idx] = val;
                    loaded[idx]  = 1'b1;
                end
            end else begin
                nxt_upd  = upd_elapsed + 1'b1;
                nxt_mode = mode_elapsed + 1'b1;
                // update check uses the mode from before this tick's switch
                if (nxt_upd >= update_interval(cur_mode)) begin
                    scaled      = (int'(entries[pos]) * 1023) / 255;
                    duty_q      = scaled[DUTY_W-1:0];
                    upd_elapsed = '0;
                    pos         = (pos + 1 >= DEPTH) ? 0 : pos + 1;
                    want.duty_updated = 1'b1;
                end else begin
                    upd_elapsed = nxt_upd;
                end
                if (nxt_mode >= period) begin
                    mode_elapsed = '0;
                    cur_mode     = (cur_mode >= MODE_LAST) ? '0 : cur_mode + 1'b1;
                    want.mode_switched = 1'b1;
                end else begin
                    mode_elapsed = nxt_mode;
                end
            end
            want.duty = duty_q;
            want.mode = cur_mode;
            pending.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(t_duty_result got);
            t_duty_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none actual duty %0d mode %0d",
                         $time, got.duty, got.mode);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("duty", 32'(want.duty), 32'(got.duty));
            compare_field("duty_updated", 32'(want.duty_updated), 32'(got.duty_updated));
            compare_field("mode", 32'(want.mode), 32'(got.mode));
            compare_field("mode_switched", 32'(want.mode_switched), 32'(got.mode_switched));
        endfunction
    endclass

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_op            = OP_TICK;
    logic [IDX_W-1:0]  i_entry_index   = '0;
    logic [BYTE_W-1:0] i_entry_value   = '0;
    logic              o_out_valid;
    logic              i_out_stall     = 1'b0;
    logic [DUTY_W-1:0] o_duty;
    logic              o_duty_updated;
    logic [MODE_W-1:0] o_mode;
    logic              o_mode_switched;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [APB_AW-1:0] paddr           = '0;
    logic [APB_DW-1:0] pwdata          = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    duty_scoreboard sb;
    t_duty_result   seen_result;
    int unsigned    tx_idle_pct = 0;
    int unsigned    rx_idle_pct = 0;
    int unsigned    cycle_count = 0;

    random_duty_pwm_sequencer_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_duty          (o_duty),
        .o_duty_updated  (o_duty_updated),
        .o_mode          (o_mode),
        .o_mode_switched (o_mode_switched),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_random_duty_pwm_sequencer_core: FAIL");
            $finish;
        end
    end

    // result monitor and random receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_result.duty          = o_duty;
            seen_result.duty_updated  = o_duty_updated;
            seen_result.mode          = o_mode;
            seen_result.mode_switched = o_mode_switched;
            sb.check_result(seen_result);
        end
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // duty byte with a bias toward the scaling breakpoints
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] corners [6] = '{8'd0, 8'd84, 8'd85, 8'd169, 8'd170, 8'd255};
        if ($urandom_range(3) == 0) return corners[$urandom_range(5)];
        return BYTE_W'($urandom());
    endfunction

    // one input transfer, with random sender gaps ahead of it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_entry_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(op, idx, val);
    endtask

    // tick with noise on the unused fields; the entry it reads is loaded first,
    // and sometimes rewritten right before the read
    task automatic send_tick();
        if (sb.next_tick_updates() && (!sb.loaded[sb.pos] || $urandom_range(1) == 0)) begin
            send_item(OP_WRITE, IDX_W'(sb.pos), pick_byte());
        end
        send_item(OP_TICK, IDX_W'($urandom()), BYTE_W'($urandom()));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // apb read of the period register, compared with the predicted value
    task automatic check_mode_period();
        logic [APB_DW-1:0] rdata;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MODE_PERIOD;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rdata[PER_W-1:0] !== sb.period) begin
            $display("%0t: mode_period_us readback mismatch, expected %0d actual %0d",
                     $time, sb.period, rdata[PER_W-1:0]);
            sb.errors++;
        end
    endtask

    // apb write of the period register while idle, then read it back
    task automatic set_mode_period(input logic [PER_W-1:0] per);
        logic [APB_DW-1:0] wdata;
        wdata = $urandom();
        wdata[PER_W-1:0] = per;
        wait_drained();
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODE_PERIOD;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_period(wdata);
        check_mode_period();
    endtask

    // mostly ticks, with table writes at random and near the read position
    task automatic run_random_phase(input int unsigned n);
        int unsigned roll;
        for (int unsigned k = 0; k < n; k++) begin
            if (k == n / 2) begin
                wait_drained();
            end
            roll = $urandom_range(99);
            if (roll < 78) begin
                send_tick();
            end else if (roll < 90) begin
                send_item(OP_WRITE, IDX_W'($urandom_range(DEPTH - 1)), pick_byte());
            end else begin
                send_item(OP_WRITE, IDX_W'((sb.pos + $urandom_range(2)) % DEPTH), pick_byte());
            end
        end
    endtask

    initial begin
        logic [PER_W-1:0] per;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_mode_period();

        // scaling breakpoints in the entries the first updates will read
        send_item(OP_WRITE, 12'd0, 8'd255);
        send_item(OP_WRITE, 12'd1, 8'd0);
        send_item(OP_WRITE, 12'd2, 8'd85);
        send_item(OP_WRITE, 12'd3, 8'd84);
        send_item(OP_WRITE, 12'd4, 8'd170);
        send_item(OP_WRITE, 12'd5, 8'd169);
        send_item(OP_WRITE, 12'd4095, 8'd90);
        // ticks under the reset period, unused fields at their extremes
        send_item(OP_TICK, 12'd4095, 8'd255);
        send_item(OP_TICK, 12'd0, 8'd0);
        send_tick();

        // zero period acts as one, and the mode counter is already past it
        set_mode_period('0);
        send_tick();
        send_tick();
        send_tick();
        send_item(OP_WRITE, 12'd2730, 8'd128);
        send_tick();
        send_tick();
        send_tick();
        send_item(OP_WRITE, 12'd1365, 8'd127);
        send_tick();
        set_mode_period(24'd1);
        send_tick();
        send_tick();

        // random phases over several periods and idle patterns
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: per = 24'd1;
                1: per = PER_W'($urandom_range(12, 2));
                2: per = '1;
                3: per = PER_W'($urandom_range(150, 100));
                4: per = PER_W'($urandom_range(5, 1));
                5: per = PERIOD_RST;
                6: per = PER_W'($urandom_range(900, 150));
                default: per = PER_W'($urandom_range(16777215, 1));
            endcase
            set_mode_period(per);
            case (p % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                1: begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 74;
                end
                default: begin
                    tx_idle_pct = 24;
                    rx_idle_pct = 24;
                end
            endcase
            run_random_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_random_duty_pwm_sequencer_core: PASS");
        end else begin
            $display("tb_random_duty_pwm_sequencer_core: FAIL");
        end
        $finish;
    end

endmodule
